// ===== hw/rtl/uhs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhs_pkg
// Shared constants, codes and bundles of the undo history stack.
// ----------------------------------------------------------------------------
package uhs_pkg;

  localparam int HIST_DEPTH = 1024;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int WORD_W     = 32;
  localparam int MODE_W     = 3;
  localparam int OPC_W      = 16;
  localparam int CNT_W      = 8;
  localparam int STEP_W     = 10;
  localparam int LIMIT_W    = 11;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(HIST_DEPTH);
  localparam logic [CNT_W-1:0]   MAX_COUNT   = 8'd254;

  // header word layout
  localparam int OPC_LSB  = 0;
  localparam int FWD_LSB  = 16;
  localparam int BACK_LSB = 24;

  typedef enum logic [MODE_W-1:0] {
    MODE_BEGIN = 3'd0,
    MODE_VALUE = 3'd1,
    MODE_BACK  = 3'd2,
    MODE_FWD   = 3'd3,
    MODE_CLEAR = 3'd4,
    MODE_READ  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TERM,
    S_REPORT
  } state_t;

  typedef enum logic [1:0] {
    RD_CURSOR,
    RD_BACK,
    RD_INDEX
  } rdsrc_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_REJECT,
    RES_ATEND,
    RES_FWD,
    RES_BACK,
    RES_READ
  } ressel_t;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rdsrc_t  rd_src;
    logic    wr_hdr;
    logic    wr_val;
    logic    wr_term;
    logic    back_move;
    logic    fwd_move;
    logic    clear;
    logic    res_load;
    ressel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              pending;
    logic              vl_last;
    logic              count_zero;
    logic              begin_ok;
    logic              cursor_zero;
    logic              cursor_at_used;
    logic              slot_free;
  } sts_t;

  typedef struct packed {
    logic              at_end;
    logic              from_start;
    logic              to_end;
    logic              rejected;
    logic [STEP_W-1:0] step_index;
    logic [OPC_W-1:0]  found_opcode;
    logic [CNT_W-1:0]  found_count;
    logic [WORD_W-1:0] read_data;
  } res_t;

  function automatic logic [CNT_W-1:0] skip_to_count(input logic [CNT_W-1:0] skip);
    return (skip == '0) ? '0 : skip - CNT_W'(1);
  endfunction

endpackage

// ===== hw/rtl/uhs_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhs channel interfaces
// Valid/ready channels for items, results and the limit register write.
// ----------------------------------------------------------------------------
interface uhs_in_if;
  import uhs_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [OPC_W-1:0]    step_opcode;
  logic [CNT_W-1:0]    value_count;
  logic [WORD_W-1:0]   value_word;
  logic [STEP_W-1:0]   read_index;
  modport source (output valid, mode, step_opcode, value_count, value_word, read_index,
                  input ready);
  modport sink   (input valid, mode, step_opcode, value_count, value_word, read_index,
                  output ready);
endinterface

interface uhs_out_if;
  import uhs_pkg::*;
  logic                valid;
  logic                ready;
  logic                at_end;
  logic                from_start;
  logic                to_end;
  logic                rejected;
  logic [STEP_W-1:0]   step_index;
  logic [OPC_W-1:0]    found_opcode;
  logic [CNT_W-1:0]    found_count;
  logic [WORD_W-1:0]   read_data;
  modport source (output valid, at_end, from_start, to_end, rejected, step_index,
                  found_opcode, found_count, read_data, input ready);
  modport sink   (input valid, at_end, from_start, to_end, rejected, step_index,
                  found_opcode, found_count, read_data, output ready);
endinterface

interface uhs_cfg_if;
  import uhs_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] history_limit;
  modport source (output valid, history_limit, input ready);
  modport sink   (input valid, history_limit, output ready);
endinterface

// ===== hw/rtl/undo_history_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// undo_history_stack
// Undo/redo history of variable-length steps in a 1024-word memory.
// ----------------------------------------------------------------------------
// One item is handled at a time and every item gives one result. Most items
// pass through the accept state, which also reads the word at the cursor,
// and the execute state. A step back and a read word add a report state for
// the second read of the single memory read port, which for a step back
// depends on the first. A begin with no values, and the last value item of a
// step, add a terminator state for the write on the single write port.
// Results pass through a one-entry holding slot ahead of the output register,
// so the next item is taken while a result waits. After reset and after a
// clear, word zero reads as an empty terminator through a flag; there is no
// clearing pass and items are taken from the first cycle out of reset. The
// limit register may be written at any time the block is idle; cfg ready is
// always high.
// ----------------------------------------------------------------------------
module undo_history_stack (
  input logic        clk,
  input logic        rst_n,
  uhs_in_if.sink     in_ch,
  uhs_out_if.source  out_ch,
  uhs_cfg_if.sink    cfg_ch
);
  import uhs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t out_res;

  assign cfg_ch.ready = 1'b1;

  uhs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uhs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_mode   (in_ch.mode),
    .in_opcode (in_ch.step_opcode),
    .in_count  (in_ch.value_count),
    .in_word   (in_ch.value_word),
    .in_index  (in_ch.read_index),
    .cfg_we    (cfg_ch.valid),
    .cfg_limit (cfg_ch.history_limit),
    .out_res   (out_res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  assign out_ch.at_end       = out_res.at_end;
  assign out_ch.from_start   = out_res.from_start;
  assign out_ch.to_end       = out_res.to_end;
  assign out_ch.rejected     = out_res.rejected;
  assign out_ch.step_index   = out_res.step_index;
  assign out_ch.found_opcode = out_res.found_opcode;
  assign out_ch.found_count  = out_res.found_count;
  assign out_ch.read_data    = out_res.read_data;

endmodule

// ===== hw/rtl/uhs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module uhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/uhs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhs_ctrl
// Sequencer: accepts an item, runs its memory accesses, queues the result.
// ----------------------------------------------------------------------------
module uhs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  uhs_pkg::sts_t sts,
  output uhs_pkg::cmd_t cmd
);
  import uhs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = sts.slot_free;
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_CURSOR;
        if (in_valid && sts.slot_free) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (sts.mode)
          MODE_BEGIN: begin
            if (!sts.begin_ok) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_REJECT;
            end else begin
              cmd.wr_hdr = 1'b1;
              if (sts.count_zero) begin
                state_nxt = S_TERM;
              end else begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_ZERO;
              end
            end
          end
          MODE_VALUE: begin
            if (!sts.pending) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_REJECT;
            end else begin
              cmd.wr_val = 1'b1;
              if (sts.vl_last) begin
                state_nxt = S_TERM;
              end else begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_ZERO;
              end
            end
          end
          MODE_BACK: begin
            if (sts.pending || sts.cursor_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ATEND;
            end else begin
              cmd.back_move = 1'b1;
              cmd.rd_en     = 1'b1;
              cmd.rd_src    = RD_BACK;
              state_nxt     = S_REPORT;
            end
          end
          MODE_FWD: begin
            cmd.res_load = 1'b1;
            if (sts.pending || sts.cursor_at_used) begin
              cmd.res_sel = RES_ATEND;
            end else begin
              cmd.fwd_move = 1'b1;
              cmd.res_sel  = RES_FWD;
            end
          end
          MODE_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ZERO;
          end
          MODE_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_INDEX;
            state_nxt  = S_REPORT;
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ZERO;
          end
        endcase
      end
      S_TERM: begin
        cmd.wr_term  = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_ZERO;
        state_nxt    = S_IDLE;
      end
      S_REPORT: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = (sts.mode == MODE_READ) ? RES_READ : RES_BACK;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // an accepted item is always executed next
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted item not executed");

  // terminator write only follows the execute cycle
  a_term_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TERM) |-> ($past(state_r) == S_EXEC))
    else $error("terminator state entered out of order");

  // items are only taken while idle
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("input ready outside idle state");

endmodule

// ===== hw/rtl/uhs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhs_datapath
// History memory, cursor and step registers, result holding and output stage.
// ----------------------------------------------------------------------------
module uhs_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  uhs_pkg::cmd_t               cmd,
  output uhs_pkg::sts_t               sts,
  input  logic [uhs_pkg::MODE_W-1:0]  in_mode,
  input  logic [uhs_pkg::OPC_W-1:0]   in_opcode,
  input  logic [uhs_pkg::CNT_W-1:0]   in_count,
  input  logic [uhs_pkg::WORD_W-1:0]  in_word,
  input  logic [uhs_pkg::STEP_W-1:0]  in_index,
  input  logic                        cfg_we,
  input  logic [uhs_pkg::LIMIT_W-1:0] cfg_limit,
  output uhs_pkg::res_t               out_res,
  output logic                        out_valid,
  input  logic                        out_ready
);
  import uhs_pkg::*;

  logic [IDX_W-1:0]   cursor_r, used_r, wp_r;
  logic [CNT_W-1:0]   vl_r, pl_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               w0_ok_r, rd_mask_r, from_start_r;

  logic [MODE_W-1:0]  mode_r;
  logic [OPC_W-1:0]   opc_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [WORD_W-1:0]  word_r;
  logic [STEP_W-1:0]  ridx_r;

  res_t res_r, res_nxt, out_r;
  logic res_v_r, out_v_r, out_free;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic [WORD_W-1:0]  rword, hdr_word, term_word;
  logic [CNT_W-1:0]   back_skip, fwd_skip;
  logic [IDX_W-1:0]   back_cur, fwd_cur, term_idx;
  logic [IDX_W+1:0]   room_need;
  logic [LIMIT_W-1:0] eff_limit;

  uhs_ram #(.WIDTH(WORD_W), .DEPTH(HIST_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // word zero reads as an empty terminator until first written after reset or a clear
  assign rword     = rd_mask_r ? '0 : ram_rdata;
  assign back_skip = rword[BACK_LSB +: CNT_W];
  assign fwd_skip  = rword[FWD_LSB +: CNT_W];
  assign back_cur  = cursor_r - IDX_W'(back_skip);
  assign fwd_cur   = cursor_r + IDX_W'(fwd_skip);
  assign term_idx  = cursor_r + IDX_W'(pl_r);
  assign out_free  = !out_v_r || out_ready;

  assign eff_limit = (limit_r > LIMIT_RESET) ? LIMIT_RESET : limit_r;
  assign room_need = (IDX_W+2)'(used_r) + (IDX_W+2)'(cnt_r) + (IDX_W+2)'(2);

  always_comb begin
    hdr_word                       = '0;
    hdr_word[BACK_LSB +: CNT_W]    = back_skip;
    hdr_word[FWD_LSB +: CNT_W]     = cnt_r + CNT_W'(1);
    hdr_word[OPC_LSB +: OPC_W]     = opc_r;
    term_word                      = '0;
    term_word[BACK_LSB +: CNT_W]   = pl_r;
  end

  always_comb begin
    case (cmd.rd_src)
      RD_BACK:  ram_raddr = back_cur;
      RD_INDEX: ram_raddr = IDX_W'(ridx_r);
      default:  ram_raddr = cursor_r;
    endcase
  end

  always_comb begin
    ram_we    = cmd.wr_hdr || cmd.wr_val || cmd.wr_term;
    ram_waddr = cursor_r;
    ram_wdata = hdr_word;
    if (cmd.wr_val) begin
      ram_waddr = wp_r;
      ram_wdata = word_r;
    end else if (cmd.wr_term) begin
      ram_waddr = term_idx;
      ram_wdata = term_word;
    end
  end

  always_comb begin
    sts.mode           = mode_r;
    sts.pending        = (vl_r != '0);
    sts.vl_last        = (vl_r == CNT_W'(1));
    sts.count_zero     = (cnt_r == '0);
    sts.begin_ok       = (vl_r == '0) && (opc_r != '0) && (cnt_r <= MAX_COUNT) &&
                         (room_need <= (IDX_W+2)'(eff_limit));
    sts.cursor_zero    = (cursor_r == '0);
    sts.cursor_at_used = (cursor_r == used_r);
    sts.slot_free      = !res_v_r || out_free;
  end

  always_comb begin
    res_nxt = '0;
    case (cmd.res_sel)
      RES_REJECT: res_nxt.rejected = 1'b1;
      RES_ATEND:  res_nxt.at_end   = 1'b1;
      RES_FWD: begin
        res_nxt.from_start   = (cursor_r == '0);
        res_nxt.to_end       = (fwd_cur == used_r);
        res_nxt.step_index   = STEP_W'(cursor_r);
        res_nxt.found_opcode = rword[OPC_LSB +: OPC_W];
        res_nxt.found_count  = skip_to_count(fwd_skip);
      end
      RES_BACK: begin
        res_nxt.from_start   = from_start_r;
        res_nxt.to_end       = (cursor_r == '0);
        res_nxt.step_index   = STEP_W'(cursor_r);
        res_nxt.found_opcode = rword[OPC_LSB +: OPC_W];
        res_nxt.found_count  = skip_to_count(fwd_skip);
      end
      RES_READ: res_nxt.read_data = rword;
      default:  res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      used_r   <= '0;
      wp_r     <= '0;
      vl_r     <= '0;
      pl_r     <= '0;
      limit_r  <= LIMIT_RESET;
      w0_ok_r  <= 1'b0;
      res_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_limit;
      end
      if (ram_we && (ram_waddr == '0)) begin
        w0_ok_r <= 1'b1;
      end
      if (cmd.wr_hdr) begin
        pl_r <= cnt_r + CNT_W'(1);
        vl_r <= cnt_r;
        wp_r <= cursor_r + IDX_W'(1);
      end
      if (cmd.wr_val) begin
        wp_r <= wp_r + IDX_W'(1);
        vl_r <= vl_r - CNT_W'(1);
      end
      if (cmd.wr_term) begin
        cursor_r <= term_idx;
        used_r   <= term_idx;
        vl_r     <= '0;
        pl_r     <= '0;
      end
      if (cmd.back_move) begin
        cursor_r <= back_cur;
      end
      if (cmd.fwd_move) begin
        cursor_r <= fwd_cur;
      end
      if (cmd.clear) begin
        cursor_r <= '0;
        used_r   <= '0;
        wp_r     <= '0;
        vl_r     <= '0;
        pl_r     <= '0;
        w0_ok_r  <= 1'b0;
      end
      if (cmd.res_load) begin
        res_v_r <= 1'b1;
      end else if (out_free) begin
        res_v_r <= 1'b0;
      end
      if (out_free) begin
        out_v_r <= res_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      opc_r  <= in_opcode;
      cnt_r  <= in_count;
      word_r <= in_word;
      ridx_r <= in_index;
    end
    if (cmd.rd_en) begin
      rd_mask_r <= (ram_raddr == '0) && !w0_ok_r;
    end
    if (cmd.back_move) begin
      from_start_r <= (cursor_r == used_r);
    end
    if (cmd.res_load) begin
      res_r <= res_nxt;
    end
    if (res_v_r && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_res   = out_r;
  assign out_valid = out_v_r;

  // the holding slot is never overwritten while full and stalled
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> sts.slot_free)
    else $error("result holding slot overwritten");

  // values still owed are always fewer than the step length
  a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
    (vl_r != '0) |-> (pl_r > vl_r))
    else $error("pending length out of step with values left");

  // finishing a step cuts the redo history at the new cursor
  a_term_cut: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_term |=> ((cursor_r == used_r) && (vl_r == '0) && (pl_r == '0)))
    else $error("step finish left cursor and used mark apart");

endmodule

// ===== tb/undo_history_stack_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// undo_history_stack_tb
// Self-checking bench for the undo history stack. A short table of directed
// items covers the corner cases, then random step sequences with noise run
// under several history limits. Every result item is checked against a table
// entry or a behavioral history model, with random gaps on both channels.
// ----------------------------------------------------------------------------
module undo_history_stack_tb;
  import uhs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;
  localparam res_t EXP_ZERO = '0;
  localparam res_t EXP_ATEND = res_t'({4'b1000, 66'd0});
  localparam res_t EXP_REJ = res_t'({4'b0001, 66'd0});
  localparam bit TYPED = 1'b1;
  localparam bit PRED = 1'b0;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [OPC_W-1:0]  opcode;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] word;
    logic [STEP_W-1:0] ridx;
  } stack_op_t;

  typedef struct packed {
    bit                 is_cfg;
    logic [LIMIT_W-1:0] lim;
    stack_op_t          op;
    bit                 typed;
    res_t               want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  uhs_in_if  in_ch();
  uhs_out_if out_ch();
  uhs_cfg_if cfg_ch();

  undo_history_stack uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // history model
  logic [WORD_W-1:0]  hist_mem [HIST_DEPTH];
  logic [IDX_W-1:0]   cur_pos;
  logic [IDX_W-1:0]   used_top;
  logic [IDX_W-1:0]   wr_ptr;
  logic [IDX_W-1:0]   hi_mark;
  logic [CNT_W-1:0]   vals_left;
  logic [CNT_W-1:0]   step_len;
  logic [LIMIT_W-1:0] lim_reg;

  res_t result_q[$];
  int   errs;
  int   cycle_cnt = 0;
  bit   steady;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_word(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] w);
    hist_mem[idx] = w;
    if (idx > hi_mark) begin
      hi_mark = idx;
    end
  endtask

  task automatic close_step();
    logic [IDX_W-1:0] t;
    t = cur_pos + IDX_W'(step_len);
    write_word(t, {step_len, 24'd0});
    cur_pos = t;
    used_top = t;
    vals_left = '0;
    step_len = '0;
  endtask

  task automatic fill_step(input logic [IDX_W-1:0] idx, inout res_t r);
    logic [CNT_W-1:0] skip;
    skip = hist_mem[idx][FWD_LSB +: CNT_W];
    r.step_index = idx;
    r.found_opcode = hist_mem[idx][OPC_LSB +: OPC_W];
    r.found_count = (skip == '0) ? '0 : skip - 8'd1;
  endtask

  task automatic apply_item(input stack_op_t it, output res_t r);
    int room;
    logic [CNT_W-1:0] bk;
    r = '0;
    case (it.mode)
      MODE_BEGIN: begin
        room = (lim_reg > HIST_DEPTH) ? HIST_DEPTH : int'(lim_reg);
        if (vals_left != '0 || it.opcode == '0 || it.count > MAX_COUNT ||
            int'(used_top) + int'(it.count) + 2 > room) begin
          r.rejected = 1'b1;
        end else begin
          write_word(cur_pos, {hist_mem[cur_pos][BACK_LSB +: CNT_W], it.count + 8'd1,
                               it.opcode});
          step_len = it.count + 8'd1;
          vals_left = it.count;
          wr_ptr = cur_pos + 1'b1;
          if (it.count == '0) begin
            close_step();
          end
        end
      end
      MODE_VALUE: begin
        if (vals_left == '0) begin
          r.rejected = 1'b1;
        end else begin
          write_word(wr_ptr, it.word);
          wr_ptr = wr_ptr + 1'b1;
          vals_left = vals_left - 1'b1;
          if (vals_left == '0) begin
            close_step();
          end
        end
      end
      MODE_BACK: begin
        if (vals_left != '0 || cur_pos == '0) begin
          r.at_end = 1'b1;
        end else begin
          r.from_start = (cur_pos == used_top);
          bk = hist_mem[cur_pos][BACK_LSB +: CNT_W];
          cur_pos = cur_pos - IDX_W'(bk);
          fill_step(cur_pos, r);
          r.to_end = (cur_pos == '0);
        end
      end
      MODE_FWD: begin
        if (vals_left != '0 || cur_pos == used_top) begin
          r.at_end = 1'b1;
        end else begin
          r.from_start = (cur_pos == '0);
          fill_step(cur_pos, r);
          cur_pos = cur_pos + IDX_W'(hist_mem[cur_pos][FWD_LSB +: CNT_W]);
          r.to_end = (cur_pos == used_top);
        end
      end
      MODE_CLEAR: begin
        cur_pos = '0;
        used_top = '0;
        wr_ptr = '0;
        vals_left = '0;
        step_len = '0;
        write_word('0, '0);
      end
      MODE_READ: begin
        r.read_data = hist_mem[it.ridx];
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input stack_op_t it, input bit typed, input res_t want);
    int gap;
    res_t r;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= it.mode;
    in_ch.step_opcode <= it.opcode;
    in_ch.value_count <= it.count;
    in_ch.value_word  <= it.word;
    in_ch.read_index  <= it.ridx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_item(it, r);
    result_q.push_back(typed ? want : r);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.history_limit <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    lim_reg = v;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed steps, with noise whether or not values are pending
  task automatic gen_item(output stack_op_t it);
    int p;
    int k;
    it.opcode = 16'($urandom_range(1, 65535));
    it.word = $urandom;
    it.ridx = 10'($urandom_range(0, HIST_DEPTH - 1));
    p = $urandom_range(0, 99);
    if (vals_left != '0) begin
      if (p < 88)      it.mode = MODE_VALUE;
      else if (p < 91) it.mode = MODE_BEGIN;
      else if (p < 93) it.mode = MODE_BACK;
      else if (p < 95) it.mode = MODE_FWD;
      else if (p < 97) it.mode = MODE_READ;
      else if (p < 99) it.mode = MODE_CLEAR;
      else             it.mode = MODE_RSVD7;
    end else begin
      if (p < 45)      it.mode = MODE_BEGIN;
      else if (p < 56) it.mode = MODE_BACK;
      else if (p < 68) it.mode = MODE_FWD;
      else if (p < 85) it.mode = MODE_READ;
      else if (p < 91) it.mode = MODE_VALUE;
      else if (p < 93) it.mode = MODE_CLEAR;
      else if (p < 96) it.mode = MODE_RSVD6;
      else             it.mode = MODE_RSVD7;
    end
    k = $urandom_range(0, 99);
    if (k < 60)      it.count = 8'($urandom_range(0, 7));
    else if (k < 88) it.count = 8'($urandom_range(8, 63));
    else if (k < 97) it.count = 8'($urandom_range(64, 254));
    else             it.count = 8'd255;
    if ($urandom_range(0, 29) == 0) begin
      it.opcode = '0;
    end
    if (it.mode == MODE_READ) begin
      it.ridx = 10'($urandom_range(0, int'(hi_mark)));
    end
  endtask

  function automatic dir_row_t item_row(input logic [MODE_W-1:0] m, input logic [OPC_W-1:0] opc,
                                        input logic [CNT_W-1:0] cnt,
                                        input logic [WORD_W-1:0] w,
                                        input logic [STEP_W-1:0] ri, input bit typed,
                                        input res_t want);
    dir_row_t r;
    r = '0;
    r.op.mode = m;
    r.op.opcode = opc;
    r.op.count = cnt;
    r.op.word = w;
    r.op.ridx = ri;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [LIMIT_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.lim = v;
    return r;
  endfunction

  // result side
  initial begin
    res_t got;
    res_t want;
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && rst_n)) @(posedge clk);
      got = {out_ch.at_end, out_ch.from_start, out_ch.to_end, out_ch.rejected,
             out_ch.step_index, out_ch.found_opcode, out_ch.found_count, out_ch.read_data};
      if (result_q.size() == 0) begin
        $error("unexpected result item");
        errs++;
      end else begin
        want = result_q.pop_front();
        if (got.at_end !== want.at_end) begin
          $error("at_end: expected %0h, got %0h", want.at_end, got.at_end);
          errs++;
        end
        if (got.from_start !== want.from_start) begin
          $error("from_start: expected %0h, got %0h", want.from_start, got.from_start);
          errs++;
        end
        if (got.to_end !== want.to_end) begin
          $error("to_end: expected %0h, got %0h", want.to_end, got.to_end);
          errs++;
        end
        if (got.rejected !== want.rejected) begin
          $error("rejected: expected %0h, got %0h", want.rejected, got.rejected);
          errs++;
        end
        if (got.step_index !== want.step_index) begin
          $error("step_index: expected %0h, got %0h", want.step_index, got.step_index);
          errs++;
        end
        if (got.found_opcode !== want.found_opcode) begin
          $error("found_opcode: expected %0h, got %0h", want.found_opcode, got.found_opcode);
          errs++;
        end
        if (got.found_count !== want.found_count) begin
          $error("found_count: expected %0h, got %0h", want.found_count, got.found_count);
          errs++;
        end
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
          errs++;
        end
      end
    end
  end

  // item side
  initial begin
    dir_row_t dir_tab[$];
    stack_op_t op;
    logic [LIMIT_W-1:0] phase_lim [4];
    int done;

    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.mode           <= MODE_BEGIN;
    in_ch.step_opcode    <= '0;
    in_ch.value_count    <= '0;
    in_ch.value_word     <= '0;
    in_ch.read_index     <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.history_limit <= LIMIT_RESET;

    errs = 0;
    steady = 1'b0;
    cur_pos = '0;
    used_top = '0;
    wr_ptr = '0;
    hi_mark = '0;
    vals_left = '0;
    step_len = '0;
    lim_reg = LIMIT_RESET;
    foreach (hist_mem[i]) hist_mem[i] = '0;

    dir_tab.push_back(item_row(MODE_READ, 0, 0, 0, 0, TYPED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_BACK, 0, 0, 0, 0, TYPED, EXP_ATEND));
    dir_tab.push_back(item_row(MODE_FWD, 0, 0, 0, 0, TYPED, EXP_ATEND));
    dir_tab.push_back(item_row(MODE_VALUE, 0, 0, 32'h1234_5678, 0, TYPED, EXP_REJ));
    dir_tab.push_back(item_row(MODE_BEGIN, 16'h0000, 8'd3, 0, 0, TYPED, EXP_REJ));
    dir_tab.push_back(item_row(MODE_BEGIN, 16'h1234, 8'd255, 0, 0, TYPED, EXP_REJ));
    dir_tab.push_back(item_row(MODE_BEGIN, 16'hFFFF, 8'd0, 0, 0, TYPED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_BEGIN, 16'h0001, 8'd2, 0, 0, TYPED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_BEGIN, 16'h0005, 8'd1, 0, 0, TYPED, EXP_REJ));
    dir_tab.push_back(item_row(MODE_BACK, 0, 0, 0, 0, TYPED, EXP_ATEND));
    dir_tab.push_back(item_row(MODE_VALUE, 0, 0, 32'hFFFF_FFFF, 0, TYPED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_VALUE, 0, 0, 32'h0000_0000, 0, TYPED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_BACK, 0, 0, 0, 0, PRED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_BACK, 0, 0, 0, 0, PRED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_BACK, 0, 0, 0, 0, PRED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_FWD, 0, 0, 0, 0, PRED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_FWD, 0, 0, 0, 0, PRED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_READ, 0, 0, 0, 10'd1, PRED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_READ, 0, 0, 0, 10'd2, PRED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_BEGIN, 16'h8000, 8'd254, 0, 0, PRED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_CLEAR, 0, 0, 0, 0, TYPED, EXP_ZERO));
    dir_tab.push_back(cfg_row(11'd2));
    dir_tab.push_back(item_row(MODE_BEGIN, 16'h0007, 8'd0, 0, 0, PRED, EXP_ZERO));
    dir_tab.push_back(item_row(MODE_BEGIN, 16'h0007, 8'd0, 0, 0, TYPED, EXP_REJ));
    dir_tab.push_back(item_row(MODE_RSVD6, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 10'h3FF, TYPED,
                               EXP_ZERO));
    dir_tab.push_back(item_row(MODE_RSVD7, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 10'h3FF, TYPED,
                               EXP_ZERO));
    dir_tab.push_back(cfg_row(LIMIT_RESET));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        write_limit(dir_tab[i].lim);
      end else begin
        send_item(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    phase_lim[0] = LIMIT_RESET;
    phase_lim[1] = 11'($urandom_range(3, 48));
    phase_lim[2] = 11'($urandom_range(49, 1023));
    phase_lim[3] = LIMIT_RESET;

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_limit(phase_lim[ph]);
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        gen_item(op);
        if ($urandom_range(0, 39) == 0) begin
          steady = !steady;
        end
        send_item(op, PRED, EXP_ZERO);
        if (op.mode <= MODE_READ) begin
          done++;
        end
      end
    end

    settle();
    if (errs == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
